// ===== rtl/core/adp_pkg.sv =====
package adp_pkg;

    localparam int DATA_W = 32;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_RSC = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    localparam logic [3:0] PC_INDEX = 4'd15;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        logic [3:0]        func;
        logic              set_flags;
        logic [DATA_W-1:0] first_operand;
        logic [DATA_W-1:0] second_operand;
        logic              shifter_carry;
        logic [3:0]        dest_index;
    } op_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              write_enable;
        logic [3:0]        dest_out;
        flags_t            flags;
        logic              restore_status;
    } res_t;

endpackage

// ===== rtl/core/adp_alu.sv =====
module adp_alu
(
    input  adp_pkg::op_t   op,
    input  adp_pkg::flags_t flags_cur,
    output adp_pkg::res_t  res
);

    logic [adp_pkg::DATA_W-1:0] add_x;
    logic [adp_pkg::DATA_W-1:0] add_y;
    logic                       add_cin;
    logic [adp_pkg::DATA_W:0]   sum;
    logic [adp_pkg::DATA_W-1:0] logic_r;
    logic [adp_pkg::DATA_W-1:0] r;
    logic                       arith;
    logic                       carry;
    logic                       ovf;
    logic                       is_test;
    adp_pkg::flags_t            f;

    // operand steering for the shared adder
    always_comb
    begin
        add_x   = op.first_operand;
        add_y   = op.second_operand;
        add_cin = 1'b0;
        arith   = 1'b1;
        logic_r = op.first_operand & op.second_operand;
        case (op.func)
            adp_pkg::OP_AND, adp_pkg::OP_TST:
            begin
                arith = 1'b0;
            end
            adp_pkg::OP_EOR, adp_pkg::OP_TEQ:
            begin
                arith   = 1'b0;
                logic_r = op.first_operand ^ op.second_operand;
            end
            adp_pkg::OP_SUB, adp_pkg::OP_CMP:
            begin
                add_y   = ~op.second_operand;
                add_cin = 1'b1;
            end
            adp_pkg::OP_RSB:
            begin
                add_x   = op.second_operand;
                add_y   = ~op.first_operand;
                add_cin = 1'b1;
            end
            adp_pkg::OP_ADD, adp_pkg::OP_CMN:
            begin
                add_cin = 1'b0;
            end
            adp_pkg::OP_ADC:
            begin
                add_cin = flags_cur.c;
            end
            adp_pkg::OP_SBC:
            begin
                add_y   = ~op.second_operand;
                add_cin = flags_cur.c;
            end
            adp_pkg::OP_RSC:
            begin
                add_x   = op.second_operand;
                add_y   = ~op.first_operand;
                add_cin = flags_cur.c;
            end
            adp_pkg::OP_ORR:
            begin
                arith   = 1'b0;
                logic_r = op.first_operand | op.second_operand;
            end
            adp_pkg::OP_MOV:
            begin
                arith   = 1'b0;
                logic_r = op.second_operand;
            end
            adp_pkg::OP_BIC:
            begin
                arith   = 1'b0;
                logic_r = op.first_operand & ~op.second_operand;
            end
            default:
            begin
                arith   = 1'b0;
                logic_r = ~op.second_operand;
            end
        endcase
    end

    assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{adp_pkg::DATA_W{1'b0}}, add_cin};
    assign carry = sum[adp_pkg::DATA_W];
    assign r     = arith ? sum[adp_pkg::DATA_W-1:0] : logic_r;
    assign ovf   = (add_x[adp_pkg::DATA_W-1] ^ r[adp_pkg::DATA_W-1])
                 & (add_y[adp_pkg::DATA_W-1] ^ r[adp_pkg::DATA_W-1]);

    assign is_test = (op.func == adp_pkg::OP_TST) || (op.func == adp_pkg::OP_TEQ)
                  || (op.func == adp_pkg::OP_CMP) || (op.func == adp_pkg::OP_CMN);

    always_comb
    begin
        f = flags_cur;
        if (op.set_flags)
        begin
            f.n = r[adp_pkg::DATA_W-1];
            f.z = (r == '0);
            f.c = arith ? carry : op.shifter_carry;
            f.v = arith ? ovf : flags_cur.v;
        end
    end

    assign res.result_value   = r;
    assign res.write_enable   = ~is_test;
    assign res.dest_out       = op.dest_index;
    assign res.flags          = f;
    assign res.restore_status = op.set_flags && (op.dest_index == adp_pkg::PC_INDEX);

endmodule

// ===== rtl/core/arm_data_processing_alu_unit.sv =====
// Result path: an accepted transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle while out_ready is high; stored NZCV updates as an op
// leaves the input register, so the next op sees it without a bubble.
// Reset: rst_n asynchronous active low; empties both stages and clears NZCV to zero.
module arm_data_processing_alu_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  func,
    input  logic        set_flags,
    input  logic [31:0] first_operand,
    input  logic [31:0] second_operand,
    input  logic        shifter_carry,
    input  logic [3:0]  dest_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_value,
    output logic        write_enable,
    output logic [3:0]  dest_out,
    output logic [3:0]  flags_out,
    output logic        restore_status
);

    logic            op_valid_reg;
    adp_pkg::op_t    op_reg;
    logic            res_valid_reg;
    adp_pkg::res_t   res_reg;
    adp_pkg::flags_t flags_reg;
    adp_pkg::res_t   res_next;
    logic            advance;

    assign advance  = op_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !op_valid_reg || advance;

    adp_alu u_alu
    (
        .op        (op_reg),
        .flags_cur (flags_reg),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                op_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                flags_reg     <= res_next.flags;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg.func           <= func;
            op_reg.set_flags      <= set_flags;
            op_reg.first_operand  <= first_operand;
            op_reg.second_operand <= second_operand;
            op_reg.shifter_carry  <= shifter_carry;
            op_reg.dest_index     <= dest_index;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = res_valid_reg;
    assign result_value   = res_reg.result_value;
    assign write_enable   = res_reg.write_enable;
    assign dest_out       = res_reg.dest_out;
    assign flags_out      = res_reg.flags;
    assign restore_status = res_reg.restore_status;

    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.flags == flags_reg))
        else $error("result flags differ from stored NZCV");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !op_reg.set_flags) |=> (flags_reg == $past(flags_reg)))
        else $error("NZCV changed without S bit");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("result register not loaded");

    a_restore_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.restore_status) |-> (res_reg.dest_out == adp_pkg::PC_INDEX))
        else $error("restore strobe without PC destination");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (op_valid_reg && res_valid_reg))
        else $error("input stalled while a stage is empty");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  func = adp_pkg::OP_AND;
    logic        set_flags = 1'b0;
    logic [31:0] first_operand = '0;
    logic [31:0] second_operand = '0;
    logic        shifter_carry = 1'b0;
    logic [3:0]  dest_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] result_value;
    logic        write_enable;
    logic [3:0]  dest_out;
    logic [3:0]  flags_out;
    logic        restore_status;

    // shadow NZCV and the results still owed by the DUT
    adp_pkg::flags_t nzcv_model = '0;
    adp_pkg::res_t   pending_results[$];
    int              error_count = 0;
    int              gap_pct = 0;
    int              stall_pct = 0;

    arm_data_processing_alu_unit DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .set_flags      (set_flags),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .shifter_carry  (shifter_carry),
        .dest_index     (dest_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_value   (result_value),
        .write_enable   (write_enable),
        .dest_out       (dest_out),
        .flags_out      (flags_out),
        .restore_status (restore_status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("arm_data_processing_alu_unit verification failed");
        $finish;
    end

    function automatic logic [31:0] add_with_carry(input logic [31:0] x, input logic [31:0] y,
                                                   input logic cin, output logic c,
                                                   output logic v);
        logic [32:0] wide;
        logic [31:0] r;
        wide = {1'b0, x} + {1'b0, y} + {32'b0, cin};
        r = wide[31:0];
        c = wide[32];
        v = (x[31] ^ r[31]) & (y[31] ^ r[31]);
        return r;
    endfunction

    function automatic adp_pkg::res_t execute_op(input adp_pkg::op_t op);
        adp_pkg::res_t   res;
        logic [31:0]     a;
        logic [31:0]     b;
        logic [31:0]     r;
        logic            c;
        logic            v;
        logic            cin;
        logic            arith;
        adp_pkg::flags_t nf;
        a = op.first_operand;
        b = op.second_operand;
        cin = nzcv_model.c;
        c = 1'b0;
        v = 1'b0;
        arith = 1'b1;
        case (op.func)
            adp_pkg::OP_AND: begin r = a & b;  arith = 1'b0; end
            adp_pkg::OP_EOR: begin r = a ^ b;  arith = 1'b0; end
            adp_pkg::OP_SUB: r = add_with_carry(a, ~b, 1'b1, c, v);
            adp_pkg::OP_RSB: r = add_with_carry(b, ~a, 1'b1, c, v);
            adp_pkg::OP_ADD: r = add_with_carry(a, b, 1'b0, c, v);
            adp_pkg::OP_ADC: r = add_with_carry(a, b, cin, c, v);
            adp_pkg::OP_SBC: r = add_with_carry(a, ~b, cin, c, v);
            adp_pkg::OP_RSC: r = add_with_carry(b, ~a, cin, c, v);
            adp_pkg::OP_TST: begin r = a & b;  arith = 1'b0; end
            adp_pkg::OP_TEQ: begin r = a ^ b;  arith = 1'b0; end
            adp_pkg::OP_CMP: r = add_with_carry(a, ~b, 1'b1, c, v);
            adp_pkg::OP_CMN: r = add_with_carry(a, b, 1'b0, c, v);
            adp_pkg::OP_ORR: begin r = a | b;  arith = 1'b0; end
            adp_pkg::OP_MOV: begin r = b;      arith = 1'b0; end
            adp_pkg::OP_BIC: begin r = a & ~b; arith = 1'b0; end
            default:         begin r = ~b;     arith = 1'b0; end
        endcase
        if (op.set_flags)
        begin
            nf.n = r[31];
            nf.z = (r == 32'd0);
            nf.c = arith ? c : op.shifter_carry;
            nf.v = arith ? v : nzcv_model.v;
            nzcv_model = nf;
        end
        res.result_value   = r;
        res.write_enable   = !(op.func >= adp_pkg::OP_TST && op.func <= adp_pkg::OP_CMN);
        res.dest_out       = op.dest_index;
        res.flags          = nzcv_model;
        res.restore_status = op.set_flags && (op.dest_index == adp_pkg::PC_INDEX);
        return res;
    endfunction

    task automatic send_op(input logic [3:0] f, input logic s, input logic [31:0] a,
                           input logic [31:0] b, input logic c, input logic [3:0] d);
        adp_pkg::op_t op;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        op = '{func: f, set_flags: s, first_operand: a, second_operand: b,
               shifter_carry: c, dest_index: d};
        in_valid       <= 1'b1;
        func           <= f;
        set_flags      <= s;
        first_operand  <= a;
        second_operand <= b;
        shifter_carry  <= c;
        dest_index     <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(execute_op(op));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // output side back-pressure
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected %h actual %h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        adp_pkg::res_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected: result_value %h",
                       result_value);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                compare_field("result_value", exp_res.result_value, result_value);
                compare_field("write_enable", 32'(exp_res.write_enable), 32'(write_enable));
                compare_field("dest_out", 32'(exp_res.dest_out), 32'(dest_out));
                compare_field("flags_out", 32'(exp_res.flags), 32'(flags_out));
                compare_field("restore_status", 32'(exp_res.restore_status),
                              32'(restore_status));
            end
        end
    end

    task automatic test_logic_ops;
        gap_pct = 20;
        stall_pct = 20;
        send_op(adp_pkg::OP_AND, 1'b1, 32'hffff_ffff, 32'h8000_0001, 1'b1, 4'd1);
        send_op(adp_pkg::OP_EOR, 1'b1, 32'hdead_beef, 32'hdead_beef, 1'b0, 4'd2);
        send_op(adp_pkg::OP_ORR, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 4'd3);
        send_op(adp_pkg::OP_MOV, 1'b1, 32'h1234_5678, 32'h0000_0000, 1'b1, 4'd4);
        send_op(adp_pkg::OP_MVN, 1'b1, 32'hffff_ffff, 32'h0000_0000, 1'b0, 4'd5);
        send_op(adp_pkg::OP_BIC, 1'b1, 32'hffff_ffff, 32'h0f0f_0f0f, 1'b1, 4'd6);
        send_op(adp_pkg::OP_TST, 1'b1, 32'h0000_f000, 32'h000f_0000, 1'b0, 4'd7);
        send_op(adp_pkg::OP_TEQ, 1'b1, 32'h8000_0000, 32'h0000_0001, 1'b1, 4'd8);
        drain();
    endtask

    task automatic test_arith_ops;
        send_op(adp_pkg::OP_ADD, 1'b1, 32'h7fff_ffff, 32'h0000_0001, 1'b0, 4'd0);
        // logic op must keep the V just set
        send_op(adp_pkg::OP_MOV, 1'b1, 32'h0, 32'h0000_0001, 1'b0, 4'd0);
        send_op(adp_pkg::OP_SUB, 1'b1, 32'h0000_0000, 32'h0000_0001, 1'b0, 4'd9);
        send_op(adp_pkg::OP_RSB, 1'b1, 32'h0000_0001, 32'h8000_0000, 1'b0, 4'd10);
        send_op(adp_pkg::OP_ADC, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 4'd11);
        send_op(adp_pkg::OP_ADC, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, 4'd12);
        send_op(adp_pkg::OP_SBC, 1'b1, 32'h0000_0005, 32'h0000_0005, 1'b0, 4'd13);
        send_op(adp_pkg::OP_RSC, 1'b1, 32'h0000_0005, 32'h0000_0005, 1'b0, 4'd14);
        send_op(adp_pkg::OP_CMP, 1'b1, 32'h8000_0000, 32'h0000_0001, 1'b0, 4'd1);
        send_op(adp_pkg::OP_CMN, 1'b1, 32'hffff_ffff, 32'h0000_0001, 1'b0, 4'd2);
        drain();
    endtask

    task automatic test_flags_without_s;
        send_op(adp_pkg::OP_CMP, 1'b0, 32'h0000_0001, 32'h0000_0001, 1'b1, 4'd3);
        send_op(adp_pkg::OP_TST, 1'b0, 32'h0000_0000, 32'hffff_ffff, 1'b1, 4'd4);
        send_op(adp_pkg::OP_ADD, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 4'd5);
        drain();
    endtask

    task automatic test_restore_pc;
        send_op(adp_pkg::OP_MOV, 1'b1, 32'h0, 32'h0000_1000, 1'b1, adp_pkg::PC_INDEX);
        send_op(adp_pkg::OP_SUB, 1'b0, 32'h0000_2004, 32'h0000_0004, 1'b0, adp_pkg::PC_INDEX);
        drain();
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_stream;
        int          phase;
        int          k;
        logic [31:0] a;
        logic [31:0] b;
        logic [3:0]  d;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       begin gap_pct = 10; stall_pct = 10; end
                1:       begin gap_pct = 30; stall_pct = 5;  end
                2:       begin gap_pct = 5;  stall_pct = 30; end
                3:       begin gap_pct = 15; stall_pct = 15; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            for (k = 0; k < 300; k++)
            begin
                a = pick_word();
                b = ($urandom_range(0, 7) == 0) ? a : pick_word();
                d = ($urandom_range(0, 3) == 0) ? adp_pkg::PC_INDEX
                                                : 4'($urandom_range(0, 15));
                send_op(4'($urandom_range(0, 15)), ($urandom_range(0, 3) != 0), a, b,
                        1'($urandom_range(0, 1)), d);
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_logic_ops();
        test_arith_ops();
        test_flags_without_s();
        test_restore_pc();
        test_random_stream();
        if (error_count == 0)
            $display("arm_data_processing_alu_unit verification clean");
        else
            $display("arm_data_processing_alu_unit verification failed");
        $finish;
    end
endmodule

// ===== arm_data_processing_alu_unit.f =====
rtl/core/adp_pkg.sv
rtl/core/adp_alu.sv
rtl/core/arm_data_processing_alu_unit.sv
sim/tb_top.sv
